/* rtl/pm0_pkg.sv */
// Shared constants and opcode codes for the PM/0 step unit.
package pm0_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int CODE_DEPTH  = 512;
    localparam int NUM_REGS    = 8;

    localparam int SADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int PC_W    = $clog2(CODE_DEPTH);
    localparam int RIDX_W  = $clog2(NUM_REGS);
    localparam int WORD_W  = 32;

    localparam logic [4:0] OP_LIT = 5'd1;
    localparam logic [4:0] OP_RTN = 5'd2;
    localparam logic [4:0] OP_LOD = 5'd3;
    localparam logic [4:0] OP_STO = 5'd4;
    localparam logic [4:0] OP_CAL = 5'd5;
    localparam logic [4:0] OP_INC = 5'd6;
    localparam logic [4:0] OP_JMP = 5'd7;
    localparam logic [4:0] OP_JPC = 5'd8;
    localparam logic [4:0] OP_SIO = 5'd9;
    localparam logic [4:0] OP_NEG = 5'd10;
    localparam logic [4:0] OP_ADD = 5'd11;
    localparam logic [4:0] OP_SUB = 5'd12;
    localparam logic [4:0] OP_MUL = 5'd13;
    localparam logic [4:0] OP_DIV = 5'd14;
    localparam logic [4:0] OP_ODD = 5'd15;
    localparam logic [4:0] OP_MOD = 5'd16;
    localparam logic [4:0] OP_EQL = 5'd17;
    localparam logic [4:0] OP_NEQ = 5'd18;
    localparam logic [4:0] OP_LSS = 5'd19;
    localparam logic [4:0] OP_LEQ = 5'd20;
    localparam logic [4:0] OP_GTR = 5'd21;
    localparam logic [4:0] OP_GEQ = 5'd22;

    localparam logic [WORD_W-1:0] SIO_WRITE = 32'd1;
    localparam logic [WORD_W-1:0] SIO_READ  = 32'd2;

endpackage

/* rtl/pm0_if.sv */
// Valid/ready channel interfaces for instruction items and result items.
interface pm0_in_if
    import pm0_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [4:0]               opcode;
    logic [2:0]               reg_sel;
    logic [9:0]               level_or_src;
    logic signed [WORD_W-1:0] operand_m;
    logic signed [WORD_W-1:0] keyboard_value;

    modport source (output valid, opcode, reg_sel, level_or_src, operand_m, keyboard_value,
                    input ready);
    modport sink (input valid, opcode, reg_sel, level_or_src, operand_m, keyboard_value,
                  output ready);
endinterface

interface pm0_out_if
    import pm0_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [PC_W-1:0]          next_pc;
    logic                     print_valid;
    logic signed [WORD_W-1:0] print_value;
    logic                     halted;
    logic                     fault;

    modport source (output valid, next_pc, print_valid, print_value, halted, fault,
                    input ready);
    modport sink (input valid, next_pc, print_valid, print_value, halted, fault,
                  output ready);
endinterface

/* rtl/pm0_register_stack_cpu_step_unit.sv */
// Top level: sequencer that executes one PM/0 instruction per item.
//
//  channel | dir | payload                                              | accepted when
//  in_ch   | in  | opcode reg_sel level_or_src operand_m keyboard_value | valid & ready
//  out_ch  | out | next_pc print_valid print_value halted fault        | valid & ready
//
// After reset the stack is swept to zero word by word; no item is taken meanwhile.
// Per item: plain opcodes take three register-file reads, one execute and one result load;
// LOD/STO/CAL add a stack read per static-link level, and these and RTN add 1 to 3 stack
// accesses; DIV/MOD wait for the iterative divider. One item at a time.
// A result waiting on out_ch does not block acceptance of the next item.
module pm0_register_stack_cpu_step_unit
    import pm0_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pm0_in_if.sink    in_ch,
    pm0_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_R, S_EXEC, S_WALK, S_WALK_WAIT,
        S_LOD_WAIT, S_RTN_A, S_RTN_B, S_CAL_BP, S_CAL_PC, S_DIV, S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [SADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [SP_W-1:0]    bp_reg, bp_next;
    logic               halt_reg, halt_next;
    logic               out_valid_reg, out_valid_next;

    logic [4:0]         op_reg, op_next;
    logic [2:0]         r_reg, r_next;
    logic [9:0]         l_reg, l_next;
    logic [WORD_W-1:0]  m_reg, m_next;
    logic [WORD_W-1:0]  kb_reg, kb_next;
    logic [WORD_W-1:0]  a_reg, a_next;
    logic [WORD_W-1:0]  b_reg, b_next;
    logic [WORD_W-1:0]  rr_reg, rr_next;
    logic [WORD_W-1:0]  walk_b_reg, walk_b_next;
    logic [9:0]         walk_cnt_reg, walk_cnt_next;
    logic [PC_W-1:0]    npc_reg, npc_next;
    logic               pv_reg, pv_next;
    logic [WORD_W-1:0]  pval_reg, pval_next;
    logic               flt_reg, flt_next;
    logic [PC_W-1:0]    o_npc_reg, o_npc_next;
    logic               o_pv_reg, o_pv_next;
    logic [WORD_W-1:0]  o_pval_reg, o_pval_next;
    logic               o_halt_reg, o_halt_next;
    logic               o_flt_reg, o_flt_next;

    logic               ram_we;
    logic [SADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;
    logic               rf_we;
    logic [RIDX_W-1:0]  rf_waddr;
    logic [WORD_W-1:0]  rf_wdata;
    logic [RIDX_W-1:0]  rf_raddr;
    logic [WORD_W-1:0]  rf_rdata;
    logic               div_start;
    logic               div_done;
    logic [WORD_W-1:0]  div_q;
    logic [WORD_W-1:0]  div_r;

    logic               in_acc;
    logic [PC_W-1:0]    pc_inc;
    logic               m_code_ok;
    logic               srcs_ok;
    logic               walk_ok;
    logic [WORD_W+1:0]  m_sext;
    logic [WORD_W+1:0]  lod_addr_w;
    logic               lod_ok;
    logic [WORD_W+1:0]  inc_w;
    logic               inc_ok;
    logic               cal_pre_ok;
    logic [SP_W-1:0]    bp_m1, bp_m2, sp_m1, sp_m2, sp_m3;
    logic [WORD_W-1:0]  odd_val;
    logic               is_arith;

    pm0_stack_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    pm0_regfile u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    pm0_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign in_acc              = in_ch.valid && in_ch.ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.next_pc      = o_npc_reg;
    assign out_ch.print_valid  = o_pv_reg;
    assign out_ch.print_value  = o_pval_reg;
    assign out_ch.halted       = o_halt_reg;
    assign out_ch.fault        = o_flt_reg;

    assign pc_inc     = (pc_reg == PC_W'(CODE_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign m_code_ok  = m_reg < WORD_W'(CODE_DEPTH);
    assign srcs_ok    = (l_reg < 10'(NUM_REGS)) && (m_reg < WORD_W'(NUM_REGS));
    assign walk_ok    = walk_b_reg < WORD_W'(STACK_DEPTH);
    assign m_sext     = {{2{m_reg[WORD_W-1]}}, m_reg};
    assign lod_addr_w = {{2{walk_b_reg[WORD_W-1]}}, walk_b_reg} - m_sext;
    assign lod_ok     = lod_addr_w < (WORD_W + 2)'(STACK_DEPTH);
    assign inc_w      = (WORD_W + 2)'(sp_reg) - m_sext;
    assign inc_ok     = inc_w <= (WORD_W + 2)'(STACK_DEPTH);
    assign cal_pre_ok = (sp_reg >= SP_W'(3)) && (sp_reg <= SP_W'(STACK_DEPTH)) && m_code_ok;
    assign bp_m1      = bp_reg - SP_W'(1);
    assign bp_m2      = bp_reg - SP_W'(2);
    assign sp_m1      = sp_reg - SP_W'(1);
    assign sp_m2      = sp_reg - SP_W'(2);
    assign sp_m3      = sp_reg - SP_W'(3);
    // remainder of R by two, truncated: -1, 0 or 1
    assign odd_val    = rf_rdata[0] ? (rf_rdata[WORD_W-1] ? '1 : WORD_W'(1)) : '0;
    assign is_arith   = (op_reg >= OP_ADD) && (op_reg <= OP_GEQ) && (op_reg != OP_ODD);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        bp_next        = bp_reg;
        halt_next      = halt_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        r_next         = r_reg;
        l_next         = l_reg;
        m_next         = m_reg;
        kb_next        = kb_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rr_next        = rr_reg;
        walk_b_next    = walk_b_reg;
        walk_cnt_next  = walk_cnt_reg;
        npc_next       = npc_reg;
        pv_next        = pv_reg;
        pval_next      = pval_reg;
        flt_next       = flt_reg;
        o_npc_next     = o_npc_reg;
        o_pv_next      = o_pv_reg;
        o_pval_next    = o_pval_reg;
        o_halt_next    = o_halt_reg;
        o_flt_next     = o_flt_reg;
        ram_we         = 1'b0;
        ram_addr       = walk_b_reg[SADDR_W-1:0];
        ram_wdata      = '0;
        rf_we          = 1'b0;
        rf_waddr       = r_reg;
        rf_wdata       = '0;
        rf_raddr       = r_reg;
        div_start      = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SADDR_W'(STACK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = in_ch.opcode;
                    r_next    = in_ch.reg_sel;
                    l_next    = in_ch.level_or_src;
                    m_next    = in_ch.operand_m;
                    kb_next   = in_ch.keyboard_value;
                    flt_next  = 1'b0;
                    pv_next   = 1'b0;
                    pval_next = '0;
                    if (halt_reg)
                    begin
                        npc_next   = pc_reg;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:
            begin
                rf_raddr   = l_reg[RIDX_W-1:0];
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                a_next     = rf_rdata;
                rf_raddr   = m_reg[RIDX_W-1:0];
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                b_next     = rf_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                rr_next    = rf_rdata;
                npc_next   = pc_inc;
                state_next = S_FINISH;
                if (is_arith && !srcs_ok)
                begin
                    flt_next = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        OP_LIT:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = m_reg;
                        end
                        OP_RTN:
                        begin
                            if (bp_reg < SP_W'(2))
                            begin
                                flt_next = 1'b1;
                            end
                            else
                            begin
                                ram_addr   = bp_m1[SADDR_W-1:0];
                                state_next = S_RTN_A;
                            end
                        end
                        OP_LOD, OP_STO:
                        begin
                            walk_b_next   = WORD_W'(bp_reg);
                            walk_cnt_next = l_reg;
                            state_next    = S_WALK;
                        end
                        OP_CAL:
                        begin
                            if (!cal_pre_ok)
                            begin
                                flt_next = 1'b1;
                            end
                            else
                            begin
                                walk_b_next   = WORD_W'(bp_reg);
                                walk_cnt_next = l_reg;
                                state_next    = S_WALK;
                            end
                        end
                        OP_INC:
                        begin
                            if (inc_ok)
                            begin
                                sp_next = inc_w[SP_W-1:0];
                            end
                            else
                            begin
                                flt_next = 1'b1;
                            end
                        end
                        OP_JMP:
                        begin
                            if (m_code_ok)
                            begin
                                npc_next = m_reg[PC_W-1:0];
                            end
                            else
                            begin
                                flt_next = 1'b1;
                            end
                        end
                        OP_JPC:
                        begin
                            if (rf_rdata == '0)
                            begin
                                if (m_code_ok)
                                begin
                                    npc_next = m_reg[PC_W-1:0];
                                end
                                else
                                begin
                                    flt_next = 1'b1;
                                end
                            end
                        end
                        OP_SIO:
                        begin
                            if (m_reg == SIO_WRITE)
                            begin
                                pv_next   = 1'b1;
                                pval_next = rf_rdata;
                            end
                            else if (m_reg == SIO_READ)
                            begin
                                rf_we    = 1'b1;
                                rf_wdata = kb_reg;
                            end
                            else
                            begin
                                halt_next = 1'b1;
                            end
                        end
                        OP_NEG:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = ~rf_rdata + 1'b1;
                        end
                        OP_ADD:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = a_reg + b_reg;
                        end
                        OP_SUB:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = a_reg - b_reg;
                        end
                        OP_MUL:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = a_reg * b_reg;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            if (b_reg == '0)
                            begin
                                flt_next = 1'b1;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        OP_ODD:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = odd_val;
                        end
                        OP_EQL:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = WORD_W'(a_reg == b_reg);
                        end
                        OP_NEQ:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = WORD_W'(a_reg != b_reg);
                        end
                        OP_LSS:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = WORD_W'($signed(a_reg) < $signed(b_reg));
                        end
                        OP_LEQ:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = WORD_W'($signed(a_reg) <= $signed(b_reg));
                        end
                        OP_GTR:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = WORD_W'($signed(a_reg) > $signed(b_reg));
                        end
                        OP_GEQ:
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = WORD_W'($signed(a_reg) >= $signed(b_reg));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (!walk_ok)
                begin
                    flt_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (walk_cnt_reg != '0)
                begin
                    ram_addr   = walk_b_reg[SADDR_W-1:0];
                    state_next = S_WALK_WAIT;
                end
                else if (op_reg == OP_CAL)
                begin
                    // static link goes first, frame is then built downward
                    ram_we     = 1'b1;
                    ram_addr   = sp_m1[SADDR_W-1:0];
                    ram_wdata  = walk_b_reg;
                    state_next = S_CAL_BP;
                end
                else if (!lod_ok)
                begin
                    flt_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (op_reg == OP_LOD)
                begin
                    ram_addr   = lod_addr_w[SADDR_W-1:0];
                    state_next = S_LOD_WAIT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_addr   = lod_addr_w[SADDR_W-1:0];
                    ram_wdata  = rr_reg;
                    state_next = S_FINISH;
                end
            end
            S_WALK_WAIT:
            begin
                walk_b_next   = ram_rdata;
                walk_cnt_next = walk_cnt_reg - 1'b1;
                state_next    = S_WALK;
            end
            S_LOD_WAIT:
            begin
                rf_we      = 1'b1;
                rf_wdata   = ram_rdata;
                state_next = S_FINISH;
            end
            S_RTN_A:
            begin
                walk_b_next = ram_rdata;
                ram_addr    = bp_m2[SADDR_W-1:0];
                state_next  = S_RTN_B;
            end
            S_RTN_B:
            begin
                if ((walk_b_reg < WORD_W'(STACK_DEPTH)) && (ram_rdata < WORD_W'(CODE_DEPTH)))
                begin
                    sp_next  = bp_reg + SP_W'(1);
                    bp_next  = walk_b_reg[SP_W-1:0];
                    npc_next = ram_rdata[PC_W-1:0];
                end
                else
                begin
                    flt_next = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_CAL_BP:
            begin
                ram_we     = 1'b1;
                ram_addr   = sp_m2[SADDR_W-1:0];
                ram_wdata  = WORD_W'(bp_reg);
                state_next = S_CAL_PC;
            end
            S_CAL_PC:
            begin
                ram_we     = 1'b1;
                ram_addr   = sp_m3[SADDR_W-1:0];
                ram_wdata  = WORD_W'(npc_reg);
                bp_next    = sp_m1;
                npc_next   = m_reg[PC_W-1:0];
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rf_we      = 1'b1;
                    rf_wdata   = (op_reg == OP_DIV) ? div_q : div_r;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_npc_next     = npc_reg;
                    o_pv_next      = pv_reg;
                    o_pval_next    = pval_reg;
                    o_halt_next    = halt_reg;
                    o_flt_next     = flt_reg;
                    pc_next        = npc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= '0;
            sp_reg        <= SP_W'(STACK_DEPTH);
            bp_reg        <= SP_W'(STACK_DEPTH - 1);
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            bp_reg        <= bp_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        r_reg        <= r_next;
        l_reg        <= l_next;
        m_reg        <= m_next;
        kb_reg       <= kb_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        rr_reg       <= rr_next;
        walk_b_reg   <= walk_b_next;
        walk_cnt_reg <= walk_cnt_next;
        npc_reg      <= npc_next;
        pv_reg       <= pv_next;
        pval_reg     <= pval_next;
        flt_reg      <= flt_next;
        o_npc_reg    <= o_npc_next;
        o_pv_reg     <= o_pv_next;
        o_pval_reg   <= o_pval_next;
        o_halt_reg   <= o_halt_next;
        o_flt_reg    <= o_flt_next;
    end
endmodule

/* rtl/pm0_stack_ram.sv */
// Single-port data stack memory with registered read.
module pm0_stack_ram
    import pm0_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [SADDR_W-1:0] addr,
    input  logic [WORD_W-1:0]  wdata,
    output logic [WORD_W-1:0]  rdata
);
    logic [WORD_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/pm0_regfile.sv */
// Eight-entry register file, one write port, one registered read port.
module pm0_regfile
    import pm0_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [RIDX_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [RIDX_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);
    logic [WORD_W-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
            rdata <= '0;
        end
        else
        begin
            if (we)
            begin
                regs_reg[waddr] <= wdata;
            end
            rdata <= regs_reg[raddr];
        end
    end
endmodule

/* rtl/pm0_divider.sv */
// Iterative signed divider: one quotient bit per cycle, C-style truncation.
module pm0_divider
    import pm0_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [WORD_W-1:0] remainder
);
    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W-1:0] d_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    assign shifted = {rem_reg, q_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_q_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_reg <= dividend[WORD_W-1];
            q_reg     <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            d_reg     <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_reg <= trial[WORD_W-1:0];
                q_reg   <= {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WORD_W-1:0];
                q_reg   <= {q_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
endmodule

/* rtl/pm0_checker.sv */
// Port-level checks for the PM/0 step unit, bound to the top level.
module pm0_checker
    import pm0_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic print_valid,
    input logic halted,
    input logic fault
);
    logic seen_halt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (out_valid && out_ready && halted)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while another is at work");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> halted)
        else $error("halted cleared after a halt");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> !print_valid && !fault)
        else $error("print or fault alongside halted");

    a_fault_no_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> !print_valid)
        else $error("print alongside fault");
endmodule

bind pm0_register_stack_cpu_step_unit pm0_checker u_pm0_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .print_valid (out_ch.print_valid),
    .halted      (out_ch.halted),
    .fault       (out_ch.fault)
);

/* bench/pm0_register_stack_cpu_step_unit_tb.sv */
// Self-checking bench for the PM/0 step unit: random programs, a local predictor, random stalls.
module pm0_register_stack_cpu_step_unit_tb
    import pm0_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          RANDOM_ITEMS   = 1250;
    localparam logic [4:0]  OP_NOP_ZERO    = 5'd0;
    localparam logic [4:0]  OP_NOP_TOP     = 5'd31;
    localparam logic [31:0] SIO_HALT       = 32'd3;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [2:0]  reg_sel;
        logic [9:0]  level_or_src;
        logic [31:0] operand_m;
        logic [31:0] keyboard_value;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            print_valid;
        logic [31:0]     print_value;
        logic            halted;
        logic            fault;
    } step_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pm0_in_if  in_ch();
    pm0_out_if out_ch();

    pm0_register_stack_cpu_step_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 clk = ~clk;

    // machine state as seen by the predictor
    logic [31:0] vm_regs [NUM_REGS];
    logic [31:0] vm_stack [STACK_DEPTH];
    longint      vm_sp, vm_bp, vm_pc;
    bit          vm_halted;

    instr_t    pending_instrs [$];
    step_out_t expected_steps [$];
    int        errors = 0;
    int        instrs_taken = 0;
    int        steps_seen = 0;
    int        faults_seen = 0;
    int        prints_seen = 0;
    int        idle_cycles = 0;
    bit        hold_done = 0;
    int        hold_left = 0;

    logic [4:0] defined_ops [22] = '{OP_LIT, OP_RTN, OP_LOD, OP_STO, OP_CAL, OP_INC, OP_JMP,
                                     OP_JPC, OP_SIO, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                                     OP_ODD, OP_MOD, OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR,
                                     OP_GEQ};

    function automatic longint sx(logic [31:0] v);
        return $signed(v);
    endfunction

    function automatic bit in_stack(longint a);
        return a >= 0 && a < STACK_DEPTH;
    endfunction

    function automatic bit in_code(longint a);
        return a >= 0 && a < CODE_DEPTH;
    endfunction

    function automatic bit follow_links(int levels, output longint found);
        longint b;
        b = vm_bp;
        found = 0;
        for (int i = 0; i < levels; i++)
        begin
            if (!in_stack(b))
                return 0;
            b = sx(vm_stack[b]);
        end
        if (!in_stack(b))
            return 0;
        found = b;
        return 1;
    endfunction

    function automatic step_out_t execute_instr(instr_t it);
        step_out_t res;
        longint    ms, a, b, t, t2, npc;
        bit        flt;
        int        r, l;
        ms  = sx(it.operand_m);
        r   = it.reg_sel;
        l   = it.level_or_src;
        flt = 0;
        a   = 0;
        b   = 0;
        res = '0;
        if (vm_halted)
        begin
            res.next_pc = vm_pc[PC_W-1:0];
            res.halted  = 1'b1;
            return res;
        end
        npc = (vm_pc + 1 >= CODE_DEPTH) ? 0 : vm_pc + 1;
        if (it.opcode >= OP_ADD && it.opcode <= OP_GEQ && it.opcode != OP_ODD)
        begin
            if (l < NUM_REGS && ms >= 0 && ms < NUM_REGS)
            begin
                a = sx(vm_regs[l]);
                b = sx(vm_regs[ms]);
            end
            else
                flt = 1;
        end
        if (!flt)
        begin
            case (it.opcode)
                OP_LIT: vm_regs[r] = it.operand_m;
                OP_RTN:
                begin
                    if (vm_bp < 2 || !in_stack(vm_bp))
                        flt = 1;
                    else
                    begin
                        t  = sx(vm_stack[vm_bp - 1]);
                        t2 = sx(vm_stack[vm_bp - 2]);
                        if (!in_stack(t) || !in_code(t2))
                            flt = 1;
                        else
                        begin
                            vm_sp = vm_bp + 1;
                            vm_bp = t;
                            npc   = t2;
                        end
                    end
                end
                OP_LOD, OP_STO:
                begin
                    if (!follow_links(l, t) || !in_stack(t - ms))
                        flt = 1;
                    else if (it.opcode == OP_LOD)
                        vm_regs[r] = vm_stack[t - ms];
                    else
                        vm_stack[t - ms] = vm_regs[r];
                end
                OP_CAL:
                begin
                    if (vm_sp < 3 || vm_sp > STACK_DEPTH || !follow_links(l, t) || !in_code(ms))
                        flt = 1;
                    else
                    begin
                        vm_stack[vm_sp - 1] = t[31:0];
                        vm_stack[vm_sp - 2] = vm_bp[31:0];
                        vm_stack[vm_sp - 3] = npc[31:0];
                        vm_bp = vm_sp - 1;
                        npc   = ms;
                    end
                end
                OP_INC:
                begin
                    t = vm_sp - ms;
                    if (t < 0 || t > STACK_DEPTH)
                        flt = 1;
                    else
                        vm_sp = t;
                end
                OP_JMP:
                begin
                    if (!in_code(ms))
                        flt = 1;
                    else
                        npc = ms;
                end
                OP_JPC:
                begin
                    if (vm_regs[r] == 0)
                    begin
                        if (!in_code(ms))
                            flt = 1;
                        else
                            npc = ms;
                    end
                end
                OP_SIO:
                begin
                    if (it.operand_m == SIO_WRITE)
                    begin
                        res.print_valid = 1'b1;
                        res.print_value = vm_regs[r];
                    end
                    else if (it.operand_m == SIO_READ)
                        vm_regs[r] = it.keyboard_value;
                    else
                        vm_halted = 1;
                end
                OP_NEG: vm_regs[r] = 32'd0 - vm_regs[r];
                OP_ADD: vm_regs[r] = 32'(a + b);
                OP_SUB: vm_regs[r] = 32'(a - b);
                OP_MUL: vm_regs[r] = 32'(a * b);
                OP_DIV:
                begin
                    if (b == 0)
                        flt = 1;
                    else
                        vm_regs[r] = 32'(a / b);
                end
                OP_ODD: vm_regs[r] = 32'(sx(vm_regs[r]) % 2);
                OP_MOD:
                begin
                    if (b == 0)
                        flt = 1;
                    else
                        vm_regs[r] = 32'(a % b);
                end
                OP_EQL: vm_regs[r] = (a == b) ? 32'd1 : 32'd0;
                OP_NEQ: vm_regs[r] = (a != b) ? 32'd1 : 32'd0;
                OP_LSS: vm_regs[r] = (a < b) ? 32'd1 : 32'd0;
                OP_LEQ: vm_regs[r] = (a <= b) ? 32'd1 : 32'd0;
                OP_GTR: vm_regs[r] = (a > b) ? 32'd1 : 32'd0;
                OP_GEQ: vm_regs[r] = (a >= b) ? 32'd1 : 32'd0;
                default: ;
            endcase
        end
        if (flt)
        begin
            res.print_valid = 1'b0;
            res.print_value = '0;
        end
        vm_pc       = npc;
        res.next_pc = vm_pc[PC_W-1:0];
        res.halted  = vm_halted;
        res.fault   = flt;
        return res;
    endfunction

    function automatic instr_t make_instr(logic [4:0] op, int r, int l, logic [31:0] m,
                                          logic [31:0] kb = 32'd0);
        instr_t it;
        it.opcode         = op;
        it.reg_sel        = r[2:0];
        it.level_or_src   = l[9:0];
        it.operand_m      = m;
        it.keyboard_value = kb;
        return it;
    endfunction

    // mostly sensible instructions; the rest is raw noise that never halts
    function automatic instr_t random_instr();
        instr_t     it;
        logic [4:0] op;
        it = make_instr(OP_NOP_ZERO, $urandom_range(0, 7), 0, 32'd0, $urandom());
        if ($urandom_range(0, 99) < 15)
        begin
            it.opcode       = $urandom_range(0, 31);
            it.level_or_src = $urandom_range(0, 1023);
            it.operand_m    = $urandom();
            if (it.opcode == OP_SIO && it.operand_m != SIO_READ)
                it.operand_m = SIO_WRITE;
            return it;
        end
        op = defined_ops[$urandom_range(0, 21)];
        it.opcode = op;
        case (op)
            OP_LIT: it.operand_m = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 20);
            OP_LOD, OP_STO:
            begin
                it.level_or_src = $urandom_range(0, 2);
                it.operand_m    = $urandom_range(0, 12) - 2;
            end
            OP_CAL:
            begin
                it.level_or_src = $urandom_range(0, 2);
                it.operand_m    = $urandom_range(0, CODE_DEPTH - 1);
            end
            OP_INC:    it.operand_m = $urandom_range(0, 20) - 8;
            OP_JMP, OP_JPC: it.operand_m = $urandom_range(0, CODE_DEPTH + 10);
            OP_SIO:    it.operand_m = $urandom_range(0, 1) ? SIO_WRITE : SIO_READ;
            OP_RTN, OP_NEG, OP_ODD: ;
            default:
            begin
                it.level_or_src = ($urandom_range(0, 49) == 0) ? 8 : $urandom_range(0, 7);
                it.operand_m    = $urandom_range(0, 7);
            end
        endcase
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH step %0d %s: got 0x%08h expected 0x%08h", steps_seen, what, got,
                 want);
        errors++;
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_steps.push_back(execute_instr({in_ch.opcode, in_ch.reg_sel,
                    in_ch.level_or_src, in_ch.operand_m, in_ch.keyboard_value}));
                instrs_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_instrs.size() > 0 &&
                    !($urandom_range(0, 99) < 12 && !(instrs_taken > 400 && instrs_taken < 600)))
                begin
                    instr_t it;
                    it = pending_instrs.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.opcode         <= it.opcode;
                    in_ch.reg_sel        <= it.reg_sel;
                    in_ch.level_or_src   <= it.level_or_src;
                    in_ch.operand_m      <= it.operand_m;
                    in_ch.keyboard_value <= it.keyboard_value;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    report_mismatch("unexpected item", 32'd1, 32'd0);
                end
                else
                begin
                    step_out_t want;
                    want = expected_steps.pop_front();
                    if (out_ch.next_pc !== want.next_pc)
                        report_mismatch("next_pc", out_ch.next_pc, want.next_pc);
                    if (out_ch.print_valid !== want.print_valid)
                        report_mismatch("print_valid", out_ch.print_valid, want.print_valid);
                    if (out_ch.print_value !== want.print_value)
                        report_mismatch("print_value", out_ch.print_value, want.print_value);
                    if (out_ch.halted !== want.halted)
                        report_mismatch("halted", out_ch.halted, want.halted);
                    if (out_ch.fault !== want.fault)
                        report_mismatch("fault", out_ch.fault, want.fault);
                    faults_seen += want.fault;
                    prints_seen += want.print_valid;
                end
                steps_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && steps_seen >= 700)
            begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (steps_seen > 400 && steps_seen < 600)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= 12);
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
            vm_regs[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
            vm_stack[i] = '0;
        vm_sp = STACK_DEPTH;
        vm_bp = STACK_DEPTH - 1;
        vm_pc = 0;
        vm_halted = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.reg_sel = '0;
        in_ch.level_or_src = '0;
        in_ch.operand_m = '0;
        in_ch.keyboard_value = '0;
        out_ch.ready = 1'b0;

        // directed opening: overflow corners, faults, jumps, frames, I/O
        pending_instrs.push_back(make_instr(OP_RTN, 0, 0, 32'd0));
        pending_instrs.push_back(make_instr(OP_LIT, 0, 0, 32'h8000_0000));
        pending_instrs.push_back(make_instr(OP_LIT, 1, 0, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(OP_DIV, 2, 0, 32'd1));
        pending_instrs.push_back(make_instr(OP_MOD, 3, 0, 32'd1));
        pending_instrs.push_back(make_instr(OP_MUL, 5, 0, 32'd0));
        pending_instrs.push_back(make_instr(OP_NEG, 0, 0, 32'd0));
        pending_instrs.push_back(make_instr(OP_ODD, 1, 0, 32'd0));
        pending_instrs.push_back(make_instr(OP_DIV, 6, 0, 32'd4));
        pending_instrs.push_back(make_instr(OP_ADD, 6, 8, 32'd0));
        pending_instrs.push_back(make_instr(OP_SUB, 6, 1, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(OP_LSS, 7, 0, 32'd1));
        pending_instrs.push_back(make_instr(OP_GEQ, 7, 1, 32'd0));
        pending_instrs.push_back(make_instr(OP_SIO, 4, 0, SIO_READ, 32'h7FFF_FFFF));
        pending_instrs.push_back(make_instr(OP_SIO, 4, 0, SIO_WRITE));
        pending_instrs.push_back(make_instr(OP_JPC, 3, 0, 32'd600));
        pending_instrs.push_back(make_instr(OP_JMP, 0, 0, CODE_DEPTH - 1));
        pending_instrs.push_back(make_instr(OP_NOP_TOP, 7, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(OP_INC, 0, 0, 32'd4));
        pending_instrs.push_back(make_instr(OP_INC, 0, 0, 32'h8000_0000));
        pending_instrs.push_back(make_instr(OP_CAL, 0, 0, 32'd40));
        pending_instrs.push_back(make_instr(OP_STO, 4, 1, 32'd3));
        pending_instrs.push_back(make_instr(OP_LOD, 5, 0, 32'd3));
        pending_instrs.push_back(make_instr(OP_RTN, 0, 0, 32'd0));
        pending_instrs.push_back(make_instr(OP_NOP_ZERO, 0, 0, 32'd0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_instrs.push_back(random_instr());
        pending_instrs.push_back(make_instr(OP_SIO, 0, 0, SIO_HALT));
        for (int i = 0; i < 5; i++)
            pending_instrs.push_back(random_instr());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_instrs.size() > 0 || in_ch.valid || expected_steps.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Ran %0d instructions, %0d results checked, %0d faults, %0d prints",
                 instrs_taken, steps_seen, faults_seen, prints_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* filelist.f */
rtl/pm0_pkg.sv
rtl/pm0_if.sv
rtl/pm0_stack_ram.sv
rtl/pm0_regfile.sv
rtl/pm0_divider.sv
rtl/pm0_register_stack_cpu_step_unit.sv
rtl/pm0_checker.sv
bench/pm0_register_stack_cpu_step_unit_tb.sv
